### hdl/sorted_set_merge_engine_assert.svh
// Assertion helpers for the sorted-set merge engine.
`ifndef SORTED_SET_MERGE_ENGINE_ASSERT_SVH
`define SORTED_SET_MERGE_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define SSME_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge, off during reset.
`define SSME_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ssme_pkg.sv
package ssme_pkg;

  localparam int SET_CAPACITY_DEF = 16;
  localparam int VAL_W            = 32;
  localparam int CMD_W            = 2;
  localparam int OP_W             = 2;
  localparam int ADDR_W           = 3;
  localparam int DATA_W           = 32;

  // Input commands
  localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN    = 2'd2;

  // Merge operations
  localparam logic [OP_W-1:0] OP_UNION = 2'd0;
  localparam logic [OP_W-1:0] OP_INTER = 2'd1;
  localparam logic [OP_W-1:0] OP_DIFF  = 2'd2;
  localparam logic [OP_W-1:0] OP_RSVD  = 2'd3;

  // Register byte addresses
  localparam logic [ADDR_W-1:0] ADDR_OPERATION = 3'd0;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;
    logic step;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;
    logic merge_end;
  } status_t;

endpackage

### hdl/sorted_set_merge_engine.sv
// Channel  | Handshake              | Payload
// ---------+------------------------+-------------------------------------
// input    | in_valid / in_ready    | command, value
// output   | out_valid / out_ready  | value_res, last, empty_res, overflow
// config   | APB psel/penable/...   | operation at byte address 0
//
// A run item walks both stores one merge step per cycle while the output
// slot is free (one compare and index advance on the registered-read stores),
// at most count_a + count_b steps, plus a closing step that emits the last
// item; no input item is taken while a run is in progress.
// Reset clears both counts, the overflow flag and the operation register;
// store contents are undefined until loaded and need no clearing.
// A stalled output holds the merge in place; a load is taken even while
// the final item of the previous run still waits in the output register.
module sorted_set_merge_engine #(
  parameter int SET_CAPACITY = ssme_pkg::SET_CAPACITY_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input items
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [ssme_pkg::CMD_W-1:0]            command,
  input  logic signed [ssme_pkg::VAL_W-1:0]     value,
  // result items
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [ssme_pkg::VAL_W-1:0]     value_res,
  output logic                                  last,
  output logic                                  empty_res,
  output logic                                  overflow,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ssme_pkg::ADDR_W-1:0]           paddr,
  input  logic [ssme_pkg::DATA_W-1:0]           pwdata,
  output logic [ssme_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready
);

  import ssme_pkg::*;

  logic [OP_W-1:0] operation;
  cmd_t            cmd;
  status_t         status;

  // Configuration: single register, zero wait states
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_OPERATION) ? DATA_W'(operation) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      operation <= OP_UNION;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_OPERATION)) begin
      operation <= pwdata[OP_W-1:0];
    end
  end

  // Sequencing: idle takes loads and runs, run steps the merge
  ssme_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // Stores, indices, merge compare and output register
  ssme_dp #(.SET_CAPACITY(SET_CAPACITY)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .operation (operation),
    .value     (value),
    .out_ready (out_ready),
    .status    (status),
    .out_valid (out_valid),
    .value_res (value_res),
    .last      (last),
    .empty_res (empty_res),
    .overflow  (overflow)
  );

`include "sorted_set_merge_engine_assert.svh"

  `SSME_ASSERT_NOW(a_empty_is_last, out_valid && empty_res, last, "empty item not marked last")
  `SSME_ASSERT_NOW(a_empty_zero, out_valid && empty_res, value_res == '0, "empty item has value")
  `SSME_ASSERT_NEXT(a_run_blocks, cmd.start, !in_ready, "input taken during run")
  `SSME_ASSERT_NEXT(a_finish_last, cmd.finish, out_valid && last, "run closed without last item")

endmodule

### hdl/ssme_ram.sv
module ssme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/ssme_ctrl.sv
module ssme_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [ssme_pkg::CMD_W-1:0]     command,
  input  ssme_pkg::status_t              status,
  output logic                           in_ready,
  output ssme_pkg::cmd_t                 cmd
);

  import ssme_pkg::*;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.load_a = accept && (command == CMD_LOAD_A);
        cmd.load_b = accept && (command == CMD_LOAD_B);
        cmd.start  = accept && (command == CMD_RUN);
        if (cmd.start) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        // advance one merge step per cycle while the output slot is free
        cmd.step   = status.slot_free && !status.merge_end;
        cmd.finish = status.slot_free && status.merge_end;
        if (cmd.finish) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hdl/ssme_dp.sv
module ssme_dp #(
  parameter int SET_CAPACITY = ssme_pkg::SET_CAPACITY_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ssme_pkg::cmd_t                        cmd,
  input  logic [ssme_pkg::OP_W-1:0]             operation,
  input  logic signed [ssme_pkg::VAL_W-1:0]     value,
  input  logic                                  out_ready,
  output ssme_pkg::status_t                     status,
  output logic                                  out_valid,
  output logic signed [ssme_pkg::VAL_W-1:0]     value_res,
  output logic                                  last,
  output logic                                  empty_res,
  output logic                                  overflow
);

  import ssme_pkg::*;

  localparam int AW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
  localparam int CW = $clog2(SET_CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(SET_CAPACITY);

  logic [CW-1:0]    count_a, count_b, idx_a, idx_b;
  logic [CW-1:0]    idx_a_next, idx_b_next;
  logic             ovf_flag;
  logic [VAL_W-1:0] rd_a, rd_b;
  logic             we_a, we_b;
  logic             hold_valid;
  logic [VAL_W-1:0] hold_value;
  logic             a_ok, b_ok, op_ok;
  logic             emit, adv_a, adv_b, merge_end;
  logic [VAL_W-1:0] emit_val;
  logic             push;

  assign we_a = cmd.load_a && (count_a < CAP);
  assign we_b = cmd.load_b && (count_b < CAP);

  ssme_ram #(.WIDTH(VAL_W), .DEPTH(SET_CAPACITY)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (count_a[AW-1:0]),
    .wdata (value),
    .raddr (idx_a_next[AW-1:0]),
    .rdata (rd_a)
  );

  ssme_ram #(.WIDTH(VAL_W), .DEPTH(SET_CAPACITY)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (count_b[AW-1:0]),
    .wdata (value),
    .raddr (idx_b_next[AW-1:0]),
    .rdata (rd_b)
  );

  assign a_ok  = idx_a < count_a;
  assign b_ok  = idx_b < count_b;
  assign op_ok = operation != OP_RSVD;

  // Merge decision on the two heads
  always_comb begin
    emit      = 1'b0;
    emit_val  = rd_a;
    adv_a     = 1'b0;
    adv_b     = 1'b0;
    merge_end = 1'b0;
    if (op_ok && a_ok && b_ok) begin
      if ($signed(rd_a) < $signed(rd_b)) begin
        emit  = operation != OP_INTER;
        adv_a = 1'b1;
      end else if ($signed(rd_b) < $signed(rd_a)) begin
        emit     = operation == OP_UNION;
        emit_val = rd_b;
        adv_b    = 1'b1;
      end else begin
        emit  = operation != OP_DIFF;
        adv_a = 1'b1;
        adv_b = 1'b1;
      end
    end else if (op_ok && a_ok && (operation != OP_INTER)) begin
      emit  = 1'b1;
      adv_a = 1'b1;
    end else if (op_ok && b_ok && (operation == OP_UNION)) begin
      emit     = 1'b1;
      emit_val = rd_b;
      adv_b    = 1'b1;
    end else begin
      merge_end = 1'b1;
    end
  end

  always_comb begin
    idx_a_next = idx_a;
    idx_b_next = idx_b;
    if (cmd.finish) begin
      idx_a_next = '0;
      idx_b_next = '0;
    end else if (cmd.step) begin
      if (adv_a) idx_a_next = idx_a + CW'(1);
      if (adv_b) idx_b_next = idx_b + CW'(1);
    end
  end

  assign status.slot_free = !out_valid || out_ready;
  assign status.merge_end = merge_end;

  // The held item goes out when a newer one replaces it or the run closes
  assign push = (cmd.step && emit && hold_valid) || cmd.finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a    <= '0;
      count_b    <= '0;
      ovf_flag   <= 1'b0;
      idx_a      <= '0;
      idx_b      <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      idx_a <= idx_a_next;
      idx_b <= idx_b_next;
      if (we_a) count_a <= count_a + CW'(1);
      if (we_b) count_b <= count_b + CW'(1);
      if ((cmd.load_a && !we_a) || (cmd.load_b && !we_b)) begin
        ovf_flag <= 1'b1;
      end
      if (cmd.finish) begin
        count_a    <= '0;
        count_b    <= '0;
        ovf_flag   <= 1'b0;
        hold_valid <= 1'b0;
      end else if (cmd.step && emit) begin
        hold_valid <= 1'b1;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && emit) begin
      hold_value <= emit_val;
    end
    if (push) begin
      overflow  <= ovf_flag;
      last      <= cmd.finish;
      empty_res <= cmd.finish && !hold_valid;
      value_res <= (cmd.finish && !hold_valid) ? '0 : hold_value;
    end
  end

endmodule

### bench/testbench.sv
module testbench;
  import ssme_pkg::*;

  // Command code with no meaning: the block must ignore the item entirely.
  localparam logic [CMD_W-1:0]  CMD_NONE   = 2'd3;
  // Byte address of a register slot that does not exist (index one).
  localparam logic [ADDR_W-1:0] ADDR_SPARE = 3'd4;

  localparam int CAP           = SET_CAPACITY_DEF;
  localparam int RAND_ITEMS    = 220;
  localparam int CALM_ITEMS    = 40;    // final stretch with no idling
  localparam int LONG_HOLD     = 150;   // one long output stall
  localparam int SETTLE_CYCLES = 4;     // let a trailing load finish before a write
  localparam int DRAIN_CYCLES  = 40;
  localparam int CYCLE_LIMIT   = 300000;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  // One result item as the block should produce it.
  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic                    last;
    logic                    empty;
    logic                    ovf;
  } merge_res_t;

  // One row of the directed table: optional register write, then one item.
  typedef struct packed {
    logic                    set_op;
    logic [OP_W-1:0]         op;
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] val;
    logic                    typed;
    merge_res_t              res;
  } stim_row_t;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  logic [CMD_W-1:0]        command   = CMD_LOAD_A;
  logic signed [VAL_W-1:0] value     = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [VAL_W-1:0] value_res;
  logic                    last;
  logic                    empty_res;
  logic                    overflow;
  logic                    psel      = 1'b0;
  logic                    penable   = 1'b0;
  logic                    pwrite    = 1'b0;
  logic [ADDR_W-1:0]       paddr     = '0;
  logic [DATA_W-1:0]       pwdata    = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;

  sorted_set_merge_engine dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value_res (value_res),
    .last      (last),
    .empty_res (empty_res),
    .overflow  (overflow),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the engine: both stores, their fill counts, the dropped-load
  // flag and the operation register.
  logic signed [VAL_W-1:0] store_a [CAP];
  logic signed [VAL_W-1:0] store_b [CAP];
  int                      cnt_a    = 0;
  int                      cnt_b    = 0;
  bit                      ovf_seen = 1'b0;
  logic [OP_W-1:0]         cfg_op   = OP_UNION;

  merge_res_t fresh [$];            // results of the item just accepted
  merge_res_t pending_results [$];  // results still owed by the block
  stim_row_t  directed_rows [$];

  int  mismatches = 0;
  int  rand_items = 0;
  bit  calm       = 1'b0;
  bit  hold_req   = 1'b0;
  bit  hold_done  = 1'b0;
  int  stall_left = 0;
  int unsigned cycle_count = 0;

  function automatic void emit_value(logic signed [VAL_W-1:0] v);
    merge_res_t r;
    r.val   = v;
    r.last  = 1'b0;
    r.empty = 1'b0;
    r.ovf   = ovf_seen;
    fresh.push_back(r);
  endfunction

  // Two-index walk over both stores; the decisions are applied as they
  // fall, so unsorted lists still give a well-defined output.
  function automatic void merge_lists();
    int i;
    int j;
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    merge_res_t r;
    i = 0;
    j = 0;
    if (cfg_op <= OP_DIFF) begin
      while (i < cnt_a && j < cnt_b) begin
        a = store_a[i];
        b = store_b[j];
        if (a < b) begin
          if (cfg_op != OP_INTER) emit_value(a);
          i++;
        end else if (b < a) begin
          if (cfg_op == OP_UNION) emit_value(b);
          j++;
        end else begin
          if (cfg_op != OP_DIFF) emit_value(a);
          i++;
          j++;
        end
      end
      // Copy each tail element once.
      if (cfg_op != OP_INTER) begin
        while (i < cnt_a) begin
          emit_value(store_a[i]);
          i++;
        end
      end
      if (cfg_op == OP_UNION) begin
        while (j < cnt_b) begin
          emit_value(store_b[j]);
          j++;
        end
      end
    end
    // Empty list, or reserved operation: a single item marked empty.
    if (fresh.size() == 0) begin
      r.val   = '0;
      r.last  = 1'b0;
      r.empty = 1'b1;
      r.ovf   = ovf_seen;
      fresh.push_back(r);
    end
    fresh[fresh.size()-1].last = 1'b1;
  endfunction

  function automatic void model_item(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] val);
    fresh.delete();
    case (cmd)
      CMD_LOAD_A: begin
        // Drop a load into a full store and remember it for the next run.
        if (cnt_a < CAP) begin
          store_a[cnt_a] = val;
          cnt_a++;
        end else begin
          ovf_seen = 1'b1;
        end
      end
      CMD_LOAD_B: begin
        if (cnt_b < CAP) begin
          store_b[cnt_b] = val;
          cnt_b++;
        end else begin
          ovf_seen = 1'b1;
        end
      end
      CMD_RUN: begin
        merge_lists();
        cnt_a    = 0;
        cnt_b    = 0;
        ovf_seen = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // Offer one item, hold it until taken, then book what it owes. A typed
  // row replaces the predicted single result with the one from the table.
  task automatic send_item(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] val,
                           bit typed, merge_res_t typed_res);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    value    <= val;
    do @(posedge clk); while (!in_ready);
    model_item(cmd, val);
    if (typed) begin
      pending_results.push_back(typed_res);
    end else begin
      foreach (fresh[k]) pending_results.push_back(fresh[k]);
    end
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_OPERATION) cfg_op = data[OP_W-1:0];
  endtask

  task automatic add_row(bit set_op, logic [OP_W-1:0] op, logic [CMD_W-1:0] cmd,
                         logic signed [VAL_W-1:0] val, bit typed,
                         logic signed [VAL_W-1:0] ev, bit el, bit ee, bit eo);
    stim_row_t row;
    row.set_op    = set_op;
    row.op        = op;
    row.cmd       = cmd;
    row.val       = val;
    row.typed     = typed;
    row.res.val   = ev;
    row.res.last  = el;
    row.res.empty = ee;
    row.res.ovf   = eo;
    directed_rows.push_back(row);
  endtask

  // One set: two lists drawn from one ascending walk so that values are
  // shared between them, loaded in random interleave, then a run.
  task automatic send_random_set();
    logic signed [VAL_W-1:0] qa [$];
    logic signed [VAL_W-1:0] qb [$];
    int     na;
    int     nb;
    int     ia;
    int     ib;
    int     step_max;
    int     seed_val;
    int     r;
    longint cur;
    r  = $urandom_range(0, 19);
    na = (r < 12) ? $urandom_range(0, 5) : (r < 17) ? $urandom_range(6, 16)
                                                     : $urandom_range(17, 19);
    r  = $urandom_range(0, 19);
    nb = (r < 12) ? $urandom_range(0, 5) : (r < 17) ? $urandom_range(6, 16)
                                                     : $urandom_range(17, 19);
    seed_val = $urandom;
    case ($urandom_range(0, 3))
      0:       cur = VAL_MIN;
      1:       cur = VAL_MAX - $urandom_range(0, 64);
      default: cur = seed_val;
    endcase
    case ($urandom_range(0, 2))
      0:       step_max = 4;
      1:       step_max = 1000;
      default: step_max = 1 << 24;
    endcase
    while (qa.size() < na || qb.size() < nb) begin
      if (qa.size() < na && qb.size() < nb && $urandom_range(0, 2) == 0) begin
        qa.push_back(cur[VAL_W-1:0]);
        qb.push_back(cur[VAL_W-1:0]);
      end else if (qa.size() < na && (qb.size() >= nb || $urandom_range(0, 1) == 1)) begin
        qa.push_back(cur[VAL_W-1:0]);
      end else begin
        qb.push_back(cur[VAL_W-1:0]);
      end
      // Repeat a value now and then; saturate at the top of the range.
      if ($urandom_range(0, 4) != 0) cur = cur + $urandom_range(1, step_max);
      if (cur > VAL_MAX) cur = VAL_MAX;
    end
    // Now and then scramble the lists to exercise unsorted input.
    if ($urandom_range(0, 7) == 0) begin
      foreach (qa[k]) qa[k] = $urandom;
      foreach (qb[k]) qb[k] = $urandom;
    end
    ia = 0;
    ib = 0;
    while (ia < qa.size() || ib < qb.size()) begin
      if ($urandom_range(0, 19) == 0) send_item(CMD_NONE, $urandom, 1'b0, '0);
      if (ia < qa.size() && (ib >= qb.size() || $urandom_range(0, 1) == 1)) begin
        send_item(CMD_LOAD_A, qa[ia], 1'b0, '0);
        ia++;
      end else begin
        send_item(CMD_LOAD_B, qb[ib], 1'b0, '0);
        ib++;
      end
      rand_items++;
      calm = (rand_items >= RAND_ITEMS - CALM_ITEMS);
    end
    send_item(CMD_RUN, $urandom, 1'b0, '0);
    rand_items++;
    calm = (rand_items >= RAND_ITEMS - CALM_ITEMS);
  endtask

  // Stimulus: reset, directed table, then random phases, each under its own
  // operation setting.
  initial begin
    int              phase;
    logic [OP_W-1:0] op;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Run before any load: empty list under the reset operation (union).
    add_row(0, OP_UNION, CMD_RUN,    '0,      1, '0, 1, 1, 0);
    // Both range extremes, a shared value, union order.
    add_row(0, OP_UNION, CMD_LOAD_A, VAL_MIN, 0, '0, 0, 0, 0);
    add_row(0, OP_UNION, CMD_LOAD_A, -32'sd5, 0, '0, 0, 0, 0);
    add_row(0, OP_UNION, CMD_LOAD_A, 32'sd7,  0, '0, 0, 0, 0);
    add_row(0, OP_UNION, CMD_LOAD_B, -32'sd5, 0, '0, 0, 0, 0);
    add_row(0, OP_UNION, CMD_LOAD_B, VAL_MAX, 0, '0, 0, 0, 0);
    add_row(0, OP_UNION, CMD_RUN,    '0,      0, '0, 0, 0, 0);
    // Intersection with one common value.
    add_row(1, OP_INTER, CMD_LOAD_A, -32'sd5, 0, '0, 0, 0, 0);
    add_row(0, OP_INTER, CMD_LOAD_A, 32'sd7,  0, '0, 0, 0, 0);
    add_row(0, OP_INTER, CMD_LOAD_B, 32'sd7,  0, '0, 0, 0, 0);
    add_row(0, OP_INTER, CMD_LOAD_B, 32'sd9,  0, '0, 0, 0, 0);
    add_row(0, OP_INTER, CMD_RUN,    '0,      1, 32'sd7, 1, 0, 0);
    // Difference of equal sets: nothing left.
    add_row(1, OP_DIFF,  CMD_LOAD_A, 32'sd1,  0, '0, 0, 0, 0);
    add_row(0, OP_DIFF,  CMD_LOAD_A, 32'sd2,  0, '0, 0, 0, 0);
    add_row(0, OP_DIFF,  CMD_LOAD_B, 32'sd1,  0, '0, 0, 0, 0);
    add_row(0, OP_DIFF,  CMD_LOAD_B, 32'sd2,  0, '0, 0, 0, 0);
    add_row(0, OP_DIFF,  CMD_RUN,    '0,      1, '0, 1, 1, 0);
    // Difference with a tail of A.
    add_row(0, OP_DIFF,  CMD_LOAD_A, -32'sd1, 0, '0, 0, 0, 0);
    add_row(0, OP_DIFF,  CMD_LOAD_A, 32'sd3,  0, '0, 0, 0, 0);
    add_row(0, OP_DIFF,  CMD_LOAD_B, 32'sd2,  0, '0, 0, 0, 0);
    add_row(0, OP_DIFF,  CMD_RUN,    '0,      0, '0, 0, 0, 0);
    // Unknown command: no result, no state change.
    add_row(0, OP_DIFF,  CMD_NONE,   -32'sd1, 0, '0, 0, 0, 0);
    // Reserved operation: always an empty list.
    add_row(1, OP_RSVD,  CMD_LOAD_A, 32'sd5,  0, '0, 0, 0, 0);
    add_row(0, OP_RSVD,  CMD_LOAD_B, 32'sd6,  0, '0, 0, 0, 0);
    add_row(0, OP_RSVD,  CMD_RUN,    '0,      1, '0, 1, 1, 0);

    foreach (directed_rows[n]) begin
      if (directed_rows[n].set_op) begin
        wait_idle();
        apb_write(ADDR_OPERATION, {$urandom_range(0, 1) ? 30'h3FFF_FFFF : 30'h0,
                                   directed_rows[n].op});
      end
      send_item(directed_rows[n].cmd, directed_rows[n].val,
                directed_rows[n].typed, directed_rows[n].res);
    end

    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      wait_idle();
      case (phase)
        0:       op = OP_DIFF;
        1:       op = OP_UNION;
        2:       op = OP_INTER;
        3:       op = OP_RSVD;
        default: op = $urandom_range(0, 3);
      endcase
      apb_write(ADDR_OPERATION, {30'($urandom), op});
      // The slot at index one does not exist: the write must change nothing.
      if (phase == 2) apb_write(ADDR_SPARE, $urandom);
      // Stall the output for a long stretch while loads and runs keep coming.
      if (phase == 1) hold_req = 1'b1;
      repeat ($urandom_range(2, 4)) send_random_set();
      phase++;
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("sorted_set_merge_engine test passed");
    end else begin
      $display("sorted_set_merge_engine test failed");
    end
    $finish;
  end

  // Output side: random stall bursts, one long hold on request, and none in
  // the final stretch.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done  <= 1'b1;
      stall_left <= LONG_HOLD - 1;
      out_ready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_ready  <= 1'b0;
    end else begin
      out_ready  <= 1'b1;
    end
  end

  // Compare each taken result with the oldest one owed. The value is
  // meaningless on an empty-list item, so skip it there.
  always @(posedge clk) begin
    merge_res_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: value %0d last %0b empty %0b overflow %0b",
                   value_res, last, empty_res, overflow);
      end else begin
        want = pending_results.pop_front();
        if (want.last !== last || want.empty !== empty_res || want.ovf !== overflow ||
            (!want.empty && want.val !== value_res)) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: want value %0d last %0b empty %0b overflow %0b",
                     want.val, want.last, want.empty, want.ovf);
            $display("  got value %0d last %0b empty %0b overflow %0b",
                     value_res, last, empty_res, overflow);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sorted_set_merge_engine test failed");
      $finish;
    end
  end

endmodule
